// File: sv/qptl_pkg.sv
// ----------------------------------------------------------------------------
// qptl_pkg
// Types, codes and helpers for the quadrotor position thrust loop
// ----------------------------------------------------------------------------
package qptl_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned NUM_LANES = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 2'd3;

  localparam logic [CFG_W-1:0] POS_GAIN_RST = 16'd2048;
  localparam logic [CFG_W-1:0] VEL_GAIN_RST = 16'd1280;
  localparam logic [CFG_W-1:0] MASS_RST     = 16'd640;
  localparam logic [CFG_W-1:0] GRAVITY_RST  = 16'd2511;

  typedef enum logic [2:0] {
    FUNC_MEAS_POS = 3'd0,
    FUNC_MEAS_VEL = 3'd1,
    FUNC_ATTITUDE = 3'd2,
    FUNC_REF_POS  = 3'd3,
    FUNC_REF_VEL  = 3'd4,
    FUNC_REF_ACC  = 3'd5,
    FUNC_REF_YAW  = 3'd6,
    FUNC_TICK     = 3'd7
  } qptl_func_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
    logic signed [31:0] val_c;
    logic signed [15:0] val_d;
  } qptl_in_t;

  typedef struct packed {
    logic signed [31:0] thrust;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] yaw_out;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic               zero_norm;
  } qptl_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] kv;
    logic [CFG_W-1:0] mass;
    logic [CFG_W-1:0] grav;
  } qptl_gains_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } qptl_quat_t;

  // one axis worth of stored state
  typedef struct packed {
    logic signed [31:0] mp;
    logic signed [31:0] mv;
    logic signed [31:0] rp;
    logic signed [31:0] rv;
    logic signed [31:0] ra;
  } qptl_comp_t;

  typedef struct packed {
    logic acc_done;
    logic div_done;
  } qptl_lane_sts_t;

  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
    if (v == 32'sh8000_0000) begin
      return 32'sh7FFF_FFFF;
    end
    return -v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    if (v > 33'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -33'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// File: sv/qptl_sqrt.sv
// ----------------------------------------------------------------------------
// qptl_sqrt
// Iterative floor square root of a 64-bit value, two radicand bits a cycle
// ----------------------------------------------------------------------------
module qptl_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] val_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;

  logic [35:0] rem_n, trial;
  logic        ge;

  assign rem_n = {rem_q[33:0], val_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_n >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      val_q  <= {val_q[61:0], 2'b00};
      rem_q  <= ge ? (rem_n - trial) : rem_n;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: sv/qptl_lane.sv
// ----------------------------------------------------------------------------
// qptl_lane
// One axis: command component, rotation column entry, thrust and norm
// partials on a shared multiplier, then the normalizing division
// ----------------------------------------------------------------------------
module qptl_lane import qptl_pkg::*; #(
  parameter int unsigned LaneIdx = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               div_start_i,
  input  logic [31:0]        norm_i,
  input  qptl_gains_t        gains_i,
  input  qptl_quat_t         quat_i,
  input  qptl_comp_t         comp_i,
  output logic signed [52:0] tp_o,
  output logic [63:0]        sq_o,
  output logic signed [15:0] axis_o,
  output qptl_lane_sts_t     sts_o
);

  logic [3:0]         step_q;
  logic               run_q, acc_done_q;
  logic signed [57:0] t_q;
  logic signed [31:0] acc_q;
  logic signed [34:0] rs_q;
  logic signed [20:0] r_q;
  logic signed [52:0] tp_q;
  logic [63:0]        sq_q;

  logic               drun_q, div_done_q, ovf_q, nz_q;
  logic [4:0]         dcnt_q;
  logic [47:0]        rem_q, dv_q;
  logic [15:0]        quo_q;
  logic signed [15:0] axis_q;

  logic signed [32:0] ma, mb, ep, ev;
  logic signed [65:0] prod;
  logic signed [34:0] p2x;
  logic signed [57:0] tr;
  logic signed [31:0] acc_sat;
  logic signed [15:0] c1a, c1b, c2a, c2b;

  assign ep = $signed({comp_i.mp[31], comp_i.mp}) - $signed({comp_i.rp[31], comp_i.rp});
  assign ev = $signed({comp_i.mv[31], comp_i.mv}) - $signed({comp_i.rv[31], comp_i.rv});

  // quaternion pairs for this entry of the third rotation column
  always_comb begin
    if (LaneIdx == 0) begin
      c1a = quat_i.x; c1b = quat_i.z; c2a = quat_i.w; c2b = quat_i.y;
    end else if (LaneIdx == 1) begin
      c1a = quat_i.y; c1b = quat_i.z; c2a = quat_i.w; c2b = quat_i.x;
    end else begin
      c1a = quat_i.x; c1b = quat_i.x; c2a = quat_i.y; c2b = quat_i.y;
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_q)
      4'd0: begin ma = ep; mb = $signed({17'b0, gains_i.kp}); end
      4'd1: begin ma = ev; mb = $signed({17'b0, gains_i.kv}); end
      4'd2: begin
        ma = $signed({comp_i.ra[31], comp_i.ra});
        mb = $signed({17'b0, gains_i.mass});
      end
      4'd3: begin
        ma = $signed({17'b0, gains_i.mass});
        mb = $signed({17'b0, gains_i.grav});
      end
      4'd4: begin
        ma = $signed({{17{c1a[15]}}, c1a});
        mb = $signed({{17{c1b[15]}}, c1b});
      end
      4'd5: begin
        ma = $signed({{17{c2a[15]}}, c2a});
        mb = $signed({{17{c2b[15]}}, c2b});
      end
      4'd7: begin
        ma = $signed({acc_q[31], acc_q});
        mb = $signed({{12{r_q[20]}}, r_q});
      end
      4'd8: begin
        ma = $signed({acc_q[31], acc_q});
        mb = $signed({acc_q[31], acc_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;
  assign p2x  = $signed({prod[33:0], 1'b0});
  assign tr   = (t_q + 58'sd128) >>> 8;

  always_comb begin
    if (tr > 58'sh7FFF_FFFF) begin
      acc_sat = 32'sh7FFF_FFFF;
    end else if (tr < -58'sh8000_0000) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = tr[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      step_q     <= '0;
      acc_done_q <= 1'b0;
    end else begin
      acc_done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'd8) begin
          run_q      <= 1'b0;
          acc_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_q) begin
      unique case (step_q)
        4'd0: t_q <= -prod[57:0];
        4'd1: t_q <= t_q - prod[57:0];
        4'd2: t_q <= t_q + prod[57:0];
        4'd3: begin
          if (LaneIdx == 2) begin
            t_q <= t_q - $signed({prod[49:0], 8'b0});
          end
        end
        4'd4: begin
          acc_q <= acc_sat;
          rs_q  <= (LaneIdx == 2) ? (35'sd268435456 - p2x) : p2x;
        end
        4'd5: rs_q <= (LaneIdx == 0) ? (rs_q + p2x) : (rs_q - p2x);
        4'd6: r_q  <= 21'((rs_q + 35'sd8192) >>> 14);
        4'd7: tp_q <= prod[52:0];
        4'd8: sq_q <= prod[63:0];
        default: ;
      endcase
    end
  end

  // normalizing division: 16 quotient bits, overflow caught up front
  logic [31:0] mag;
  logic [47:0] dividend;
  logic        ge;
  logic [16:0] lim, m17, sel;

  assign mag      = acc_q[31] ? 32'(-acc_q) : acc_q;
  assign dividend = {2'b00, mag, 14'b0} + {17'b0, norm_i[31:1]};
  assign ge       = rem_q >= dv_q;
  assign lim      = (acc_q > 32'sd0) ? 17'd32768 : 17'd32767;
  assign m17      = ovf_q ? 17'h1FFFF : {1'b0, quo_q};
  assign sel      = (m17 > lim) ? lim : m17;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drun_q     <= 1'b0;
      dcnt_q     <= '0;
      div_done_q <= 1'b0;
    end else begin
      div_done_q <= 1'b0;
      if (div_start_i) begin
        drun_q <= 1'b1;
        dcnt_q <= 5'd16;
      end else if (drun_q) begin
        if (dcnt_q == 5'd0) begin
          drun_q     <= 1'b0;
          div_done_q <= 1'b1;
        end else begin
          dcnt_q <= dcnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start_i) begin
      rem_q <= dividend;
      dv_q  <= {1'b0, norm_i, 15'b0};
      ovf_q <= dividend >= {norm_i, 16'b0};
      nz_q  <= norm_i != 32'd0;
      quo_q <= '0;
    end else if (drun_q) begin
      if (dcnt_q != 5'd0) begin
        if (ge) begin
          rem_q <= rem_q - dv_q;
        end
        quo_q <= {quo_q[14:0], ge};
        dv_q  <= {1'b0, dv_q[47:1]};
      end else begin
        if (!nz_q) begin
          axis_q <= '0;
        end else if (acc_q > 32'sd0) begin
          axis_q <= 16'(-sel);
        end else begin
          axis_q <= sel[15:0];
        end
      end
    end
  end

  assign tp_o           = tp_q;
  assign sq_o           = sq_q;
  assign axis_o         = axis_q;
  assign sts_o.acc_done = acc_done_q;
  assign sts_o.div_done = div_done_q;

endmodule

// File: sv/quadrotor_position_thrust_loop_core.sv
// ----------------------------------------------------------------------------
// quadrotor_position_thrust_loop_core
// Outer position loop: stores measurements and references, and on a tick
// forms the thrust command, desired body axis, yaw and reference position
//
//   channel   direction  payload      handshake
//   in        input      qptl_in_t    in_valid_i / in_stall_o
//   out       output     qptl_out_t   out_valid_o / out_stall_i
//   cfg       input      16-bit reg   cfg_we_i, cfg_idx_i
//
// update items give no item back
// a tick runs through the lane multipliers, the merge, the square root unit,
// the lane dividers and the output load
// the input stalls while a tick is in work or its result cannot be loaded
// reset clears the stored measurements, references, attitude and yaw and restores the default gains
// ----------------------------------------------------------------------------
module quadrotor_position_thrust_loop_core import qptl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  qptl_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qptl_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_q, state_d;
  qptl_gains_t        gains_q;
  qptl_quat_t         quat_q;
  qptl_comp_t [NUM_LANES-1:0] comp_q;
  logic signed [15:0] yaw_q;
  logic               seen_q;
  logic signed [31:0] thrust_q;
  logic               out_valid_q;
  qptl_out_t          out_q;

  logic               in_acc, lane_start, sqrt_start, sqrt_busy, sqrt_done, load_out;
  logic [31:0]        root;
  logic signed [15:0] yaw_in;
  logic signed [52:0] tp [NUM_LANES];
  logic [63:0]        sq [NUM_LANES];
  logic signed [15:0] axis [NUM_LANES];
  qptl_lane_sts_t     sts [NUM_LANES];

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign lane_start = in_acc && (in_data_i.func == FUNC_TICK) && seen_q;
  assign sqrt_start = state_q == S_SUM;
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign yaw_in     = sat16({in_data_i.val_a[31], in_data_i.val_a});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (lane_start) state_d = S_ACC;
      S_ACC:  if (sts[0].acc_done) state_d = S_SUM;
      S_SUM:  state_d = S_SQRT;
      S_SQRT: if (sqrt_done) state_d = S_DIV;
      S_DIV:  if (sts[0].div_done) state_d = S_OUT;
      S_OUT:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      gains_q.kp   <= POS_GAIN_RST;
      gains_q.kv   <= VEL_GAIN_RST;
      gains_q.mass <= MASS_RST;
      gains_q.grav <= GRAVITY_RST;
      quat_q       <= '0;
      comp_q       <= '0;
      yaw_q        <= '0;
      seen_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POS_GAIN: gains_q.kp   <= cfg_data_i;
          REG_VEL_GAIN: gains_q.kv   <= cfg_data_i;
          REG_MASS:     gains_q.mass <= cfg_data_i;
          REG_GRAVITY:  gains_q.grav <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        unique case (in_data_i.func)
          FUNC_MEAS_POS: begin
            comp_q[0].mp <= in_data_i.val_a;
            comp_q[1].mp <= in_data_i.val_b;
            comp_q[2].mp <= in_data_i.val_c;
          end
          FUNC_MEAS_VEL: begin
            comp_q[0].mv <= in_data_i.val_a;
            comp_q[1].mv <= in_data_i.val_b;
            comp_q[2].mv <= in_data_i.val_c;
          end
          FUNC_ATTITUDE: begin
            quat_q.w <= sat16({in_data_i.val_a[31], in_data_i.val_a});
            quat_q.x <= sat16({in_data_i.val_b[31], in_data_i.val_b});
            quat_q.y <= sat16({in_data_i.val_c[31], in_data_i.val_c});
            quat_q.z <= in_data_i.val_d;
          end
          FUNC_REF_POS: begin
            comp_q[0].rp <= in_data_i.val_a;
            comp_q[1].rp <= neg_sat32(in_data_i.val_b);
            comp_q[2].rp <= neg_sat32(in_data_i.val_c);
            seen_q       <= 1'b1;
          end
          FUNC_REF_VEL: begin
            comp_q[0].rv <= in_data_i.val_a;
            comp_q[1].rv <= neg_sat32(in_data_i.val_b);
            comp_q[2].rv <= neg_sat32(in_data_i.val_c);
          end
          FUNC_REF_ACC: begin
            comp_q[0].ra <= in_data_i.val_a;
            comp_q[1].ra <= neg_sat32(in_data_i.val_b);
            comp_q[2].ra <= neg_sat32(in_data_i.val_c);
          end
          FUNC_REF_YAW: begin
            yaw_q <= sat16(-{{17{yaw_in[15]}}, yaw_in});
          end
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge of the lane partials: thrust and squared norm
  logic signed [54:0] tsum;
  logic signed [40:0] trnd;
  logic signed [41:0] tneg;
  logic [63:0]        n2;

  assign tsum = 55'(tp[0]) + 55'(tp[1]) + 55'(tp[2]);
  assign trnd = 41'((tsum + 55'sd8192) >>> 14);
  assign tneg = -$signed({trnd[40], trnd});
  assign n2   = sq[0] + sq[1] + sq[2];

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      if (tneg > 42'sh7FFF_FFFF) begin
        thrust_q <= 32'sh7FFF_FFFF;
      end else if (tneg < -42'sh8000_0000) begin
        thrust_q <= 32'sh8000_0000;
      end else begin
        thrust_q <= tneg[31:0];
      end
    end
    if (load_out) begin
      out_q.thrust    <= thrust_q;
      out_q.axis_x    <= axis[0];
      out_q.axis_y    <= axis[1];
      out_q.axis_z    <= axis[2];
      out_q.yaw_out   <= yaw_q;
      out_q.ref_x     <= comp_q[0].rp;
      out_q.ref_y     <= comp_q[1].rp;
      out_q.ref_z     <= comp_q[2].rp;
      out_q.zero_norm <= root == 32'd0;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    qptl_lane #(
      .LaneIdx(g)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .start_i     (lane_start),
      .div_start_i (sqrt_done),
      .norm_i      (root),
      .gains_i     (gains_q),
      .quat_i      (quat_q),
      .comp_i      (comp_q[g]),
      .tp_o        (tp[g]),
      .sq_o        (sq[g]),
      .axis_o      (axis[g]),
      .sts_o       (sts[g])
    );
  end

  qptl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (n2),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sqrt_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_busy |-> state_q == S_SQRT)
    else $error("square root running outside its phase");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts[0].acc_done == sts[1].acc_done && sts[1].acc_done == sts[2].acc_done)
    else $error("lanes out of step");

  a_zero_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_norm |->
      out_data_o.axis_x == 16'sd0 && out_data_o.axis_y == 16'sd0 &&
      out_data_o.axis_z == 16'sd0)
    else $error("zero norm with nonzero axis");

endmodule
